>>> hw/rtl/bqe_pkg.sv
package bqe_pkg;

    localparam int MAX_BATCH = 16384;
    localparam int CORDIC_STEPS = 16;

    localparam logic [2:0] REG_RIGHT_X = 3'd0;
    localparam logic [2:0] REG_RIGHT_Y = 3'd1;
    localparam logic [2:0] REG_RIGHT_Z = 3'd2;
    localparam logic [2:0] REG_UP_X    = 3'd3;
    localparam logic [2:0] REG_UP_Y    = 3'd4;
    localparam logic [2:0] REG_UP_Z    = 3'd5;

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    typedef struct packed {
        logic       load;
        logic       cordic;
        logic       round;
        logic       basis;
        logic       prod;
        logic       emit;
        logic [3:0] step;
    } bqe_cmd_t;

    function automatic logic signed [17:0] atan_entry(input logic [3:0] i);
        logic signed [17:0] r;
        case (i)
            4'd0:    r = 18'sd8192;
            4'd1:    r = 18'sd4836;
            4'd2:    r = 18'sd2555;
            4'd3:    r = 18'sd1297;
            4'd4:    r = 18'sd651;
            4'd5:    r = 18'sd326;
            4'd6:    r = 18'sd163;
            4'd7:    r = 18'sd81;
            4'd8:    r = 18'sd41;
            4'd9:    r = 18'sd20;
            4'd10:   r = 18'sd10;
            4'd11:   r = 18'sd5;
            4'd12:   r = 18'sd3;
            4'd13:   r = 18'sd1;
            4'd14:   r = 18'sd1;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/bqe_ctl.sv
module bqe_ctl
    import bqe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output bqe_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CORDIC,
        S_ROUND,
        S_BASIS,
        S_PROD,
        S_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       can_emit;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign can_emit  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.step       = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CORDIC;
                    step_next  = '0;
                end
            end
            S_CORDIC:
            begin
                cmd.cordic = 1'b1;
                step_next  = step_reg + 4'd1;
                if (step_reg == 4'(CORDIC_STEPS - 1))
                begin
                    state_next = S_ROUND;
                    step_next  = '0;
                end
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_BASIS;
            end
            S_BASIS:
            begin
                cmd.basis = 1'b1;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd5)
                begin
                    state_next = S_PROD;
                    step_next  = '0;
                end
            end
            S_PROD:
            begin
                cmd.prod  = 1'b1;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd2)
                begin
                    state_next = S_EMIT;
                    step_next  = '0;
                end
            end
            S_EMIT:
            begin
                if (can_emit)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    step_next      = step_reg + 4'd1;
                    if (step_reg == 4'd3)
                    begin
                        state_next = S_IDLE;
                        step_next  = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/bqe_dp.sv
module bqe_dp
    import bqe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  bqe_cmd_t           cmd,
    input  logic               cfg_valid,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [31:0]        quad_size,
    input  logic [15:0]        spin_angle,
    input  logic [31:0]        color_rgba,
    input  logic [15:0]        texture_id,
    input  logic [2:0]         blend_mode,
    input  logic               draw_start,
    output logic signed [31:0] vert_x,
    output logic signed [31:0] vert_y,
    output logic signed [31:0] vert_z,
    output logic [31:0]        vert_rgba,
    output logic               tex_u,
    output logic               tex_v,
    output logic [15:0]        vertex_index,
    output logic               batch_begin,
    output logic [15:0]        batch_texture,
    output logic [2:0]         batch_blend,
    output logic               last_corner
);

    logic signed [15:0] right_reg [3];
    logic signed [15:0] up_reg [3];

    logic [15:0] batch_texture_reg;
    logic [2:0]  batch_blend_reg;
    logic [14:0] quads_in_batch_reg;
    logic        batch_open_reg;
    logic        fresh;

    logic signed [31:0] pos_reg [3];
    logic [31:0]        size_reg;
    logic [31:0]        rgba_reg;
    logic [13:0]        quad_base_reg;
    logic               fresh_reg;

    logic signed [33:0] cx_reg, cy_reg;
    logic signed [17:0] cz_reg;
    logic               flip_reg;
    logic signed [15:0] cos_reg, sin_reg;
    logic signed [17:0] basis_reg [6];
    logic signed [50:0] prod_reg [6];

    logic signed [31:0] vx_reg, vy_reg, vz_reg;
    logic [31:0]        vrgba_reg;
    logic               u_reg, v_reg, begin_reg, last_reg;
    logic [15:0]        vidx_reg, btex_reg;
    logic [2:0]         bblend_reg;

    logic signed [33:0] sh_x, sh_y;
    logic signed [17:0] rx_round, ry_round;
    logic signed [15:0] c_clamp, s_clamp;
    logic [1:0]         bi;
    logic signed [15:0] ba, bb;
    logic signed [31:0] pa, pb;
    logic signed [32:0] bsum;
    logic [1:0]         pj;
    logic signed [32:0] size_s;
    logic [1:0]         corner;
    logic               sx, sy;
    logic signed [31:0] vert_calc [3];

    function automatic logic signed [15:0] clamp_q14(input logic signed [33:0] v);
        logic signed [33:0] t;
        logic signed [17:0] r;
        t = (v + 34'sd32768) >>> 16;
        r = t[17:0];
        if (r > 18'sd16384)
            return 16'sd16384;
        else if (r < -18'sd16384)
            return -16'sd16384;
        else
            return r[15:0];
    endfunction

    function automatic logic signed [31:0] corner_val(
        input logic signed [31:0] pos,
        input logic signed [50:0] rp,
        input logic signed [50:0] up,
        input logic               px,
        input logic               py);
        logic signed [51:0] sum;
        logic signed [51:0] off;
        logic signed [37:0] v;
        sum = (px ? 52'(rp) : -52'(rp)) + (py ? 52'(up) : -52'(up));
        off = (sum + 52'sd16384) >>> 15;
        v   = 38'(pos) + off[37:0];
        if (v > 38'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -38'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    assign fresh = draw_start || !batch_open_reg || (texture_id != batch_texture_reg)
                || (blend_mode != batch_blend_reg)
                || (quads_in_batch_reg >= 15'(MAX_BATCH));

    assign sh_x     = cx_reg >>> cmd.step;
    assign sh_y     = cy_reg >>> cmd.step;
    assign c_clamp  = clamp_q14(cx_reg);
    assign s_clamp  = clamp_q14(cy_reg);
    assign rx_round = 18'(c_clamp);
    assign ry_round = 18'(s_clamp);

    always_comb
    begin
        bi = (cmd.step >= 4'd3) ? 2'(cmd.step - 4'd3) : cmd.step[1:0];
        if (cmd.step >= 4'd3)
        begin
            ba = up_reg[bi];
            bb = right_reg[bi];
        end
        else
        begin
            ba = right_reg[bi];
            bb = up_reg[bi];
        end
        pa = ba * cos_reg;
        pb = bb * sin_reg;
        if (cmd.step >= 4'd3)
            bsum = 33'(pa) - 33'(pb) + 33'sd8192;
        else
            bsum = 33'(pa) + 33'(pb) + 33'sd8192;
    end

    assign pj     = cmd.step[1:0];
    assign size_s = $signed({1'b0, size_reg});
    assign corner = cmd.step[1:0];
    assign sx     = (corner == 2'd1) || (corner == 2'd2);
    assign sy     = (corner == 2'd0) || (corner == 2'd1);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vert_calc[i] = corner_val(pos_reg[i], prod_reg[i], prod_reg[i + 3], sx, sy);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_reg[0]       <= 16'sd16384;
            right_reg[1]       <= 16'sd0;
            right_reg[2]       <= 16'sd0;
            up_reg[0]          <= 16'sd0;
            up_reg[1]          <= 16'sd16384;
            up_reg[2]          <= 16'sd0;
            batch_texture_reg  <= '0;
            batch_blend_reg    <= '0;
            quads_in_batch_reg <= '0;
            batch_open_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_RIGHT_X: right_reg[0] <= cfg_data;
                    REG_RIGHT_Y: right_reg[1] <= cfg_data;
                    REG_RIGHT_Z: right_reg[2] <= cfg_data;
                    REG_UP_X:    up_reg[0]    <= cfg_data;
                    REG_UP_Y:    up_reg[1]    <= cfg_data;
                    REG_UP_Z:    up_reg[2]    <= cfg_data;
                    default:     ;
                endcase
            end
            if (cmd.load)
            begin
                batch_open_reg <= 1'b1;
                if (fresh)
                begin
                    batch_texture_reg  <= texture_id;
                    batch_blend_reg    <= blend_mode;
                    quads_in_batch_reg <= 15'd1;
                end
                else
                begin
                    quads_in_batch_reg <= quads_in_batch_reg + 15'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_reg[0]    <= pos_x;
            pos_reg[1]    <= pos_y;
            pos_reg[2]    <= pos_z;
            size_reg      <= quad_size;
            rgba_reg      <= color_rgba;
            fresh_reg     <= fresh;
            quad_base_reg <= fresh ? 14'd0 : quads_in_batch_reg[13:0];
            cx_reg        <= CORDIC_X0;
            cy_reg        <= '0;
            if (spin_angle >= 16'd16384 && spin_angle < 16'd49152)
            begin
                flip_reg <= 1'b1;
                cz_reg   <= 18'($signed({2'b00, spin_angle})) - 18'sd32768;
            end
            else
            begin
                flip_reg <= 1'b0;
                cz_reg   <= 18'($signed(spin_angle));
            end
        end
        if (cmd.cordic)
        begin
            if (!cz_reg[17])
            begin
                cx_reg <= cx_reg - sh_y;
                cy_reg <= cy_reg + sh_x;
                cz_reg <= cz_reg - atan_entry(cmd.step);
            end
            else
            begin
                cx_reg <= cx_reg + sh_y;
                cy_reg <= cy_reg - sh_x;
                cz_reg <= cz_reg + atan_entry(cmd.step);
            end
        end
        if (cmd.round)
        begin
            cos_reg <= flip_reg ? 16'(-rx_round) : c_clamp;
            sin_reg <= flip_reg ? 16'(-ry_round) : s_clamp;
        end
        if (cmd.basis)
        begin
            basis_reg[cmd.step[2:0] < 3'd6 ? cmd.step[2:0] : 3'd0] <= bsum[31:14];
        end
        if (cmd.prod)
        begin
            prod_reg[pj]          <= basis_reg[pj] * size_s;
            prod_reg[3'(pj) + 3'd3] <= basis_reg[3'(pj) + 3'd3] * size_s;
        end
        if (cmd.emit)
        begin
            vx_reg     <= vert_calc[0];
            vy_reg     <= vert_calc[1];
            vz_reg     <= vert_calc[2];
            vrgba_reg  <= rgba_reg;
            u_reg      <= sx;
            v_reg      <= (corner == 2'd2) || (corner == 2'd3);
            vidx_reg   <= {quad_base_reg, corner};
            begin_reg  <= fresh_reg && (corner == 2'd0);
            btex_reg   <= batch_texture_reg;
            bblend_reg <= batch_blend_reg;
            last_reg   <= (corner == 2'd3);
        end
    end

    assign vert_x        = vx_reg;
    assign vert_y        = vy_reg;
    assign vert_z        = vz_reg;
    assign vert_rgba     = vrgba_reg;
    assign tex_u         = u_reg;
    assign tex_v         = v_reg;
    assign vertex_index  = vidx_reg;
    assign batch_begin   = begin_reg;
    assign batch_texture = btex_reg;
    assign batch_blend   = bblend_reg;
    assign last_corner   = last_reg;

endmodule

>>> hw/rtl/billboard_quad_expander.sv
// Billboard quad expander. Each particle request on the input channel
// (in_valid/in_ready) yields four corner requests on the output channel
// (out_valid/out_ready): top-left, top-right, bottom-right, bottom-left.
// The camera basis is written through the configuration channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data), which is always ready;
// write it only while no particle is in flight.
// A particle runs a CORDIC iteration for sine and cosine, a rounding
// step, basis rotation into six terms on two shared multipliers and
// the size products. Its corners then follow one per cycle while the
// receiver takes them; a new particle is accepted only after the last
// corner has been emitted. The CORDIC iteration is the longest phase.
// in_ready is high only between particles. The last corner sits in the
// output register while the next particle is accepted. When the receiver
// stalls, the corner on the port holds and no further corner is produced.
// Reset restores the identity basis and closes the current batch.
module billboard_quad_expander
    import bqe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [31:0]        quad_size,
    input  logic [15:0]        spin_angle,
    input  logic [31:0]        color_rgba,
    input  logic [15:0]        texture_id,
    input  logic [2:0]         blend_mode,
    input  logic               draw_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] vert_x,
    output logic signed [31:0] vert_y,
    output logic signed [31:0] vert_z,
    output logic [31:0]        vert_rgba,
    output logic               tex_u,
    output logic               tex_v,
    output logic [15:0]        vertex_index,
    output logic               batch_begin,
    output logic [15:0]        batch_texture,
    output logic [2:0]         batch_blend,
    output logic               last_corner,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    bqe_cmd_t cmd;

    assign cfg_ready = 1'b1;

    bqe_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    bqe_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .quad_size     (quad_size),
        .spin_angle    (spin_angle),
        .color_rgba    (color_rgba),
        .texture_id    (texture_id),
        .blend_mode    (blend_mode),
        .draw_start    (draw_start),
        .vert_x        (vert_x),
        .vert_y        (vert_y),
        .vert_z        (vert_z),
        .vert_rgba     (vert_rgba),
        .tex_u         (tex_u),
        .tex_v         (tex_v),
        .vertex_index  (vertex_index),
        .batch_begin   (batch_begin),
        .batch_texture (batch_texture),
        .batch_blend   (batch_blend),
        .last_corner   (last_corner)
    );

endmodule
